// ----- hdl/cvma_pkg.sv -----
// ----------------------------------------------------------------------------
// cvma_pkg
// shared constants and types of the cascaded moving average filter
// ----------------------------------------------------------------------------
package cvma_pkg;
	localparam int unsigned HistoryDepthDefault = 4096;
	localparam int unsigned StageCountDefault   = 4;
	localparam int unsigned SampleWidth         = 24;
	localparam int unsigned WindowWidth         = 12;
	localparam int unsigned SumWidth            = 36;

	typedef logic signed [SampleWidth-1:0] sample_t;
	typedef logic [WindowWidth-1:0]        window_t;
	typedef logic signed [SumWidth-1:0]    sum_t;

	// divider request and response
	typedef struct packed {
		logic    start;
		sum_t    dividend;
		window_t divisor;
	} div_req_t;

	typedef struct packed {
		logic    done;
		sample_t quotient;
	} div_rsp_t;
endpackage

// ----- hdl/cvma_divider.sv -----
// ----------------------------------------------------------------------------
// cvma_divider
// serial signed divide, one quotient bit per cycle, truncated toward zero
// ----------------------------------------------------------------------------
module cvma_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  cvma_pkg::div_req_t req,
	output cvma_pkg::div_rsp_t rsp
);
	import cvma_pkg::*;

	localparam int unsigned CntWidth = $clog2(SumWidth + 1);

	logic [SumWidth-1:0]    rem_q;
	logic [SumWidth-1:0]    quo_q;
	logic [WindowWidth-1:0] den_q;
	logic                   neg_q;
	logic                   busy_q;
	logic [CntWidth-1:0]    cnt_q;
	logic                   fin_q;
	logic                   done_q;
	sample_t                quot_q;

	logic [SumWidth-1:0] mag;
	logic [SumWidth:0]   shifted;
	logic [SumWidth:0]   trial;
	logic [SumWidth-1:0] qneg;

	assign mag     = req.dividend[SumWidth-1] ? SumWidth'(-req.dividend)
	                                          : SumWidth'(req.dividend);
	assign shifted = {rem_q, quo_q[SumWidth-1]};
	assign trial   = shifted - {{(SumWidth+1-WindowWidth){1'b0}}, den_q};
	assign qneg    = neg_q ? SumWidth'(-quo_q) : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntWidth'(SumWidth);
				rem_q  <= '0;
				quo_q  <= mag;
				den_q  <= req.divisor;
				neg_q  <= req.dividend[SumWidth-1];
			end else if (busy_q) begin
				if (!trial[SumWidth]) begin
					rem_q <= trial[SumWidth-1:0];
					quo_q <= {quo_q[SumWidth-2:0], 1'b1};
				end else begin
					rem_q <= shifted[SumWidth-1:0];
					quo_q <= {quo_q[SumWidth-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntWidth'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// result is valid once the last iteration has passed through fin_q into done_q and quot_q
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			fin_q  <= busy_q && cnt_q == CntWidth'(1);
			done_q <= fin_q;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_q) begin
			quot_q <= qneg[SampleWidth-1:0];
		end
	end

	assign rsp = '{done: done_q, quotient: quot_q};
endmodule

// ----- hdl/cvma_history.sv -----
// ----------------------------------------------------------------------------
// cvma_history
// history memory of all stages, one port read and one write, registered read
// ----------------------------------------------------------------------------
module cvma_history #(
	parameter int unsigned AddrWidth = 14
) (
	input  logic                   clk,
	input  logic                   wr_en,
	input  logic [AddrWidth-1:0]   wr_addr,
	input  cvma_pkg::sample_t      wr_data,
	input  logic [AddrWidth-1:0]   rd_addr,
	output cvma_pkg::sample_t      rd_data
);
	import cvma_pkg::*;

	sample_t mem [2**AddrWidth];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule

// ----- hdl/cascaded_variable_moving_average.sv -----
// ----------------------------------------------------------------------------
// cascaded_variable_moving_average
// four boxcar averages in cascade with a shared, slewing window length
// ----------------------------------------------------------------------------
// s_axis carries one sample and a window request per transfer; m_axis returns
// the output of the last stage and the window applied to that sample.
// One item is worked at a time. Each stage reads up to two old samples from
// the shared history memory (one read a cycle), writes the new sample, then
// runs a serial 36-step divide. The memory steps are ST_RD1, ST_RD2 and
// ST_WAIT; ST_DIV then waits for the divide and its result. A new input is
// taken only after the last item has moved into the output register.
// After reset the block first clears the whole history memory, one entry a
// cycle, all 16384 entries by default, with s_axis_tready low. Sums, window
// and ring position reset to zero.
// The result sits in an output register. The next item may be worked while it
// waits; that item then holds in its output step with s_axis_tready low until
// the receiver takes the result, so a stalled receiver loses nothing.
// ----------------------------------------------------------------------------
module cascaded_variable_moving_average #(
	parameter int unsigned HISTORY_DEPTH = cvma_pkg::HistoryDepthDefault,
	parameter int unsigned STAGE_COUNT   = cvma_pkg::StageCountDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [23:0] sample_in, [35:24] window_request, [39:36] zero
	input  logic [39:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [23:0] sample_out, [35:24] window_in_use, [39:36] zero
	output logic [39:0] m_axis_tdata
);
	import cvma_pkg::*;

	localparam int unsigned PosWidth   = $clog2(HISTORY_DEPTH);
	localparam int unsigned PosExt     = PosWidth + 1;
	localparam int unsigned StgWidth   = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1;
	localparam int unsigned AddrWidth  = PosWidth + StgWidth;
	localparam int unsigned Limit      = HISTORY_DEPTH - 1;

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_RD1, ST_RD2, ST_WAIT, ST_DIV, ST_OUT
	} state_t;

	state_t                 state_q;
	logic [AddrWidth-1:0]   clr_q;
	logic [PosWidth-1:0]    pos_q;
	window_t                win_q;
	window_t                neww_q;
	logic                   grow_q;
	logic                   shrink_q;
	logic [StgWidth-1:0]    stg_q;
	sample_t                x_q;
	sum_t                   sum_q;
	sum_t                   sums_q [STAGE_COUNT];
	logic                   out_valid_q;
	sample_t                out_sample_q;
	window_t                out_win_q;
	logic                   rd1_pending_q;
	logic                   rd2_pending_q;

	logic                   wr_en;
	logic [AddrWidth-1:0]   wr_addr;
	sample_t                wr_data;
	logic [AddrWidth-1:0]   rd_addr;
	sample_t                rd_data;
	div_req_t               dreq;
	div_rsp_t               drsp;

	sample_t                in_sample;
	window_t                in_req;
	window_t                target;
	logic [PosWidth-1:0]    back_dist;
	logic [PosWidth:0]      back_diff;
	logic [PosWidth-1:0]    back_pos;
	sum_t                   new_sum;
	logic                   out_load;

	assign in_sample = s_axis_tdata[23:0];
	assign in_req    = s_axis_tdata[35:24];

	always_comb begin
		target = in_req;
		if (target == '0) begin
			target = window_t'(1);
		end
		if ({20'd0, target} > 32'(Limit)) begin
			target = window_t'(Limit);
		end
	end

	// first read step (used unless growing) reads oldw back, shrink then reads oldw - 1 back, ring wraps at depth
	always_comb begin
		if (state_q == ST_RD1) begin
			back_dist = PosWidth'(win_q);
		end else begin
			back_dist = PosWidth'(win_q - 1'b1);
		end
		back_diff = {1'b0, pos_q} - {1'b0, back_dist};
		if (back_diff[PosWidth]) begin
			back_diff = back_diff + PosExt'(HISTORY_DEPTH);
		end
		back_pos = back_diff[PosWidth-1:0];
	end

	assign rd_addr  = {stg_q, back_pos};
	assign wr_en    = (state_q == ST_CLEAR) || (state_q == ST_WAIT);
	assign wr_addr  = (state_q == ST_CLEAR) ? clr_q : {stg_q, pos_q};
	assign wr_data  = (state_q == ST_CLEAR) ? '0 : x_q;

	cvma_history #(.AddrWidth(AddrWidth)) u_hist (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// sum_q already holds the new sample, the shrink read lands here
	assign new_sum = rd2_pending_q ? sum_q - SumWidth'(rd_data) : sum_q;

	assign dreq = '{start: state_q == ST_WAIT, dividend: new_sum, divisor: neww_q};

	cvma_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	assign out_load      = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'd0, out_win_q, out_sample_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			clr_q         <= '0;
			pos_q         <= '0;
			win_q         <= '0;
			neww_q        <= '0;
			grow_q        <= 1'b0;
			shrink_q      <= 1'b0;
			stg_q         <= '0;
			out_valid_q   <= 1'b0;
			rd1_pending_q <= 1'b0;
			rd2_pending_q <= 1'b0;
			for (int i = 0; i < STAGE_COUNT; i++) begin
				sums_q[i] <= '0;
			end
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			// old samples arrive in the cycle after their read
			rd1_pending_q <= (state_q == ST_RD1) && !grow_q;
			rd2_pending_q <= (state_q == ST_RD2) && shrink_q;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						x_q   <= in_sample;
						stg_q <= '0;
						sum_q <= sums_q[0] + SumWidth'(in_sample);
						if (target > win_q) begin
							grow_q   <= 1'b1;
							shrink_q <= 1'b0;
							neww_q   <= win_q + 1'b1;
						end else begin
							grow_q   <= 1'b0;
							shrink_q <= target < win_q;
							neww_q   <= (target < win_q) ? win_q - 1'b1 : win_q;
						end
						state_q <= ST_RD1;
					end
				end
				ST_RD1: begin
					state_q <= ST_RD2;
				end
				ST_RD2: begin
					if (rd1_pending_q) begin
						sum_q <= sum_q - SumWidth'(rd_data);
					end
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					// writing the new sample, sum now final for this stage
					sums_q[stg_q] <= new_sum;
					state_q       <= ST_DIV;
				end
				ST_DIV: begin
					if (drsp.done) begin
						x_q <= drsp.quotient;
						if (stg_q == StgWidth'(STAGE_COUNT - 1)) begin
							state_q <= ST_OUT;
						end else begin
							stg_q   <= stg_q + 1'b1;
							sum_q   <= sums_q[stg_q + 1'b1] + SumWidth'(drsp.quotient);
							state_q <= ST_RD1;
						end
					end
				end
				ST_OUT: begin
					if (out_load) begin
						out_sample_q <= x_q;
						out_win_q    <= neww_q;
						win_q        <= neww_q;
						pos_q        <= (pos_q == PosWidth'(Limit)) ? '0 : pos_q + 1'b1;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// window moves by at most one per transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && s_axis_tvalid) |=>
		(neww_q == win_q + 1'b1 || neww_q == win_q || neww_q == win_q - 1'b1))
		else $error("window slew exceeds one");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (neww_q != '0))
		else $error("zero divisor");

	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("result overwritten");
endmodule

// ----- dv/cascaded_variable_moving_average_test.sv -----
// ----------------------------------------------------------------------------
// cascaded_variable_moving_average_test
// self-checking bench for the cascaded variable moving average filter
// ----------------------------------------------------------------------------
// a queue of samples with window requests feeds a driver with random gaps; a
// monitor with random stalls compares each output transfer with a local
// predictor of the four cascaded boxcar stages and the slewing window.
// ----------------------------------------------------------------------------
module cascaded_variable_moving_average_test;
	import cvma_pkg::*;

	localparam int unsigned Depth  = HistoryDepthDefault;
	localparam int unsigned Stages = StageCountDefault;

	typedef struct packed {
		sample_t sample;
		window_t window;
	} avg_item_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;

	avg_item_t pending_q[$];
	avg_item_t expected_q[$];
	int        errors;
	bit        hold_sender;
	int        send_gap;
	int        recv_gap;

	// predictor state
	sample_t   hist[Stages][Depth];
	int unsigned ring_pos;
	longint    sums[Stages];
	int unsigned win_now;

	cascaded_variable_moving_average u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return 0;
		if (r < 90) return $urandom_range(1, 4);
		return $urandom_range(20, 300);
	endfunction

	function automatic sample_t hist_back(int unsigned st, int unsigned k);
		return hist[st][(ring_pos + Depth - (k % Depth)) % Depth];
	endfunction

	function automatic avg_item_t average_step(avg_item_t in);
		avg_item_t   res;
		longint      x;
		int unsigned tgt;
		int unsigned neww;
		bit          grow;
		bit          shrink;
		x = longint'(in.sample);
		tgt = in.window;
		if (tgt == 0) tgt = 1;
		if (tgt > Depth - 1) tgt = Depth - 1;
		grow = tgt > win_now;
		shrink = !grow && tgt < win_now;
		neww = grow ? win_now + 1 : (shrink ? win_now - 1 : win_now);
		for (int st = 0; st < Stages; st++) begin
			if (!grow) sums[st] -= longint'(hist_back(st, win_now));
			if (shrink) sums[st] -= longint'(hist_back(st, win_now - 1));
			hist[st][ring_pos] = sample_t'(x);
			sums[st] += x;
			x = sums[st] / longint'(neww);
		end
		win_now = neww;
		ring_pos = (ring_pos + 1) % Depth;
		res.sample = sample_t'(x);
		res.window = window_t'(neww);
		return res;
	endfunction

	function automatic avg_item_t make_item(int unsigned w);
		avg_item_t it;
		it.sample = sample_t'($urandom());
		it.window = window_t'(w);
		return it;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			send_gap      <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_q.push_back(average_step(pending_q.pop_front()));
				s_axis_tvalid <= 1'b0;
				send_gap      <= pick_gap();
			end else if (s_axis_tvalid) begin
				// hold current transfer
			end else if (send_gap > 0) begin
				send_gap <= send_gap - 1;
			end else if (pending_q.size() > 0 && !hold_sender) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= {4'b0, pending_q[0].window, pending_q[0].sample};
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		avg_item_t got;
		avg_item_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			recv_gap      <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.sample = m_axis_tdata[23:0];
				got.window = m_axis_tdata[35:24];
				if (expected_q.size() == 0) begin
					$error("unexpected output transfer %h", m_axis_tdata);
					errors++;
				end else begin
					want = expected_q.pop_front();
					if (got.sample !== want.sample) begin
						$error("sample_out expected %0d actual %0d", want.sample, got.sample);
						errors++;
					end
					if (got.window !== want.window) begin
						$error("window_in_use expected %0d actual %0d", want.window, got.window);
						errors++;
					end
				end
				if (m_axis_tdata[39:36] !== 4'b0) begin
					$error("pad expected 0 actual %h", m_axis_tdata[39:36]);
					errors++;
				end
				recv_gap <= pick_gap();
				m_axis_tready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin
		int unsigned w;
		int          r;
		errors = 0;
		hold_sender = 1'b1;
		ring_pos = 0;
		win_now = 0;
		for (int st = 0; st < Stages; st++) begin
			sums[st] = 0;
			for (int i = 0; i < Depth; i++) hist[st][i] = '0;
		end
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, zero request, maximum window request, grow, hold, shrink
		pending_q.push_back('{sample: 24'sh7fffff, window: 12'd0});
		pending_q.push_back('{sample: 24'sh800000, window: 12'd4095});
		pending_q.push_back('{sample: 24'sh7fffff, window: 12'd4095});
		pending_q.push_back('{sample: 24'sh800000, window: 12'd4095});
		pending_q.push_back('{sample: 24'sh000001, window: 12'd3});
		pending_q.push_back('{sample: 24'shffffff, window: 12'd3});
		pending_q.push_back('{sample: 24'sh7fffff, window: 12'd0});
		pending_q.push_back('{sample: 24'sh800000, window: 12'd0});
		pending_q.push_back('{sample: 24'sh555555, window: 12'd2});
		pending_q.push_back('{sample: 24'shaaaaaa, window: 12'd2});
		for (int i = 0; i < 8; i++) pending_q.push_back(make_item(12'hfff));
		pending_q.push_back('{sample: 24'sh123456, window: 12'd1});
		pending_q.push_back('{sample: 24'shedcba9, window: 12'd1});
		hold_sender = 1'b0;

		// random: window requests mostly settle near small lengths
		for (int blk = 0; blk < 26; blk++) begin
			r = $urandom_range(0, 9);
			if (r < 6) w = $urandom_range(1, 24);
			else if (r < 8) w = $urandom_range(0, 4095);
			else w = (r == 8) ? 0 : 4095;
			for (int i = 0; i < 25; i++) begin
				if ($urandom_range(0, 9) == 0) pending_q.push_back(make_item($urandom_range(0, 4095)));
				else pending_q.push_back(make_item(w));
			end
			if (blk == 12) begin
				while (pending_q.size() != 0) @(posedge clk);
				hold_sender = 1'b1;
				while (expected_q.size() != 0) @(posedge clk);
				hold_sender = 1'b0;
			end
		end
		while (pending_q.size() != 0) @(posedge clk);
		while (expected_q.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (errors == 0) $display("end of test: clean");
		else $display("end of test: mismatches");
		$finish;
	end

	initial begin
		#4000000;
		$display("end of test: mismatches");
		$finish;
	end
endmodule

// ----- files.f -----
hdl/cvma_pkg.sv
hdl/cvma_divider.sv
hdl/cvma_history.sv
hdl/cascaded_variable_moving_average.sv
dv/cascaded_variable_moving_average_test.sv
